// ----- rtl/assert_macros.svh -----
// Assertion helper macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, skipped while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sti_pkg.sv -----
`default_nettype none
package sti_pkg;
    localparam int COORD_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int POINT_BITS     = 60;
    localparam int MARGIN_BITS    = 20;
    localparam int IN_BITS        = 5 * POINT_BITS;
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 20'd1;
endpackage
`default_nettype wire

// ----- rtl/sti_vec.sv -----
`default_nettype none
// Stages 1-2: edge/difference vectors, then the two cross products.
module sti_vec #(
    parameter int COORD_BITS = sti_pkg::COORD_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [sti_pkg::IN_BITS-1:0] pts,
    output logic signed [COORD_BITS:0]       e1_o [3],
    output logic signed [COORD_BITS:0]       e2_o [3],
    output logic signed [COORD_BITS:0]       d_o  [3],
    output logic signed [COORD_BITS:0]       s_o  [3],
    output logic signed [2*COORD_BITS+2:0]   h_o  [3],
    output logic signed [2*COORD_BITS+2:0]   q_o  [3]
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW + 1;

    logic signed [DW-1:0] e1_reg [3], e2_reg [3], d_reg [3], s_reg [3];
    logic signed [DW-1:0] e1_next [3], e2_next [3], d_next [3], s_next [3];
    logic signed [PW-1:0] h_reg [3], q_reg [3], h_next [3], q_next [3];
    logic signed [DW-1:0] e1_dl [3], e2_dl [3], d_dl [3], s_dl [3];

    function automatic logic signed [DW-1:0] crd(input logic [sti_pkg::POINT_BITS-1:0] w,
                                                 input int k);
        logic signed [COORD_BITS-1:0] c;
        c = w[k*COORD_BITS +: COORD_BITS];
        return DW'(c);
    endfunction

    // differences: e1 = b - a, e2 = c - a, d = end - start, s = start - a
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1_next[k] = crd(pts[239:180], k) - crd(pts[179:120], k);
            e2_next[k] = crd(pts[299:240], k) - crd(pts[179:120], k);
            d_next[k]  = crd(pts[119:60], k) - crd(pts[59:0], k);
            s_next[k]  = crd(pts[59:0], k) - crd(pts[179:120], k);
        end
    end

    // cross products h = d x e2, q = s x e1
    always_comb begin
        h_next[0] = PW'(d_reg[1]) * PW'(e2_reg[2]) - PW'(d_reg[2]) * PW'(e2_reg[1]);
        h_next[1] = PW'(d_reg[2]) * PW'(e2_reg[0]) - PW'(d_reg[0]) * PW'(e2_reg[2]);
        h_next[2] = PW'(d_reg[0]) * PW'(e2_reg[1]) - PW'(d_reg[1]) * PW'(e2_reg[0]);
        q_next[0] = PW'(s_reg[1]) * PW'(e1_reg[2]) - PW'(s_reg[2]) * PW'(e1_reg[1]);
        q_next[1] = PW'(s_reg[2]) * PW'(e1_reg[0]) - PW'(s_reg[0]) * PW'(e1_reg[2]);
        q_next[2] = PW'(s_reg[0]) * PW'(e1_reg[1]) - PW'(s_reg[1]) * PW'(e1_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg <= e1_next; e2_reg <= e2_next; d_reg <= d_next; s_reg <= s_next;
            h_reg <= h_next; q_reg <= q_next;
            e1_dl <= e1_reg; e2_dl <= e2_reg; d_dl <= d_reg; s_dl <= s_reg;
        end
    end

    assign e1_o = e1_dl;
    assign e2_o = e2_dl;
    assign d_o  = d_dl;
    assign s_o  = s_dl;
    assign h_o  = h_reg;
    assign q_o  = q_reg;
endmodule
`default_nettype wire

// ----- rtl/sti_dot.sv -----
`default_nettype none
// Stages 3-5: split products, dot sums, then sign fold and bound compares.
module sti_dot #(
    parameter int COORD_BITS = sti_pkg::COORD_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [sti_pkg::MARGIN_BITS-1:0]   margin,
    input  wire logic signed [COORD_BITS:0]        e1_i [3],
    input  wire logic signed [COORD_BITS:0]        e2_i [3],
    input  wire logic signed [COORD_BITS:0]        d_i  [3],
    input  wire logic signed [COORD_BITS:0]        s_i  [3],
    input  wire logic signed [2*COORD_BITS+2:0]    h_i  [3],
    input  wire logic signed [2*COORD_BITS+2:0]    q_i  [3],
    output logic                                   hit_o
);
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW + 1;
    localparam int MW  = DW + PW;
    localparam int SW  = MW + 3;
    // cross term split: low LW bits unsigned, upper PW-LW bits signed
    localparam int LW  = DW + 1;
    localparam int HW  = DW + PW - LW;
    localparam int LPW = DW + LW + 1;

    logic signed [HW-1:0]  pdh_reg [3], puh_reg [3], pvh_reg [3], pth_reg [3];
    logic signed [LPW-1:0] pdl_reg [3], pul_reg [3], pvl_reg [3], ptl_reg [3];
    logic signed [SW-1:0]  det_reg, un_reg, vn_reg, tn_reg;
    logic signed [SW-1:0]  det_a, un_a, vn_a, tn_a, uv_a;
    logic                  hit_reg, hit_next;

    // upper part of a cross term times a vector coordinate
    function automatic logic signed [HW-1:0] mul_hi(input logic signed [DW-1:0] a,
                                                    input logic signed [PW-1:0] b);
        logic signed [HW-1:0] ax, bx;
        ax = HW'(a);
        bx = HW'($signed(b[PW-1:LW]));
        return ax * bx;
    endfunction

    // lower (unsigned) part of a cross term times a vector coordinate
    function automatic logic signed [LPW-1:0] mul_lo(input logic signed [DW-1:0] a,
                                                     input logic signed [PW-1:0] b);
        logic signed [LPW-1:0] ax, bx;
        ax = LPW'(a);
        bx = LPW'($signed({1'b0, b[LW-1:0]}));
        return ax * bx;
    endfunction

    // rebuild one full product from its two parts
    function automatic logic signed [SW-1:0] term(input logic signed [HW-1:0] hi,
                                                  input logic signed [LPW-1:0] lo);
        return (SW'(hi) <<< LW) + SW'(lo);
    endfunction

    // sign fold and range checks
    always_comb begin
        if (det_reg < 0) begin
            det_a = -det_reg; un_a = -un_reg; vn_a = -vn_reg; tn_a = -tn_reg;
        end else begin
            det_a = det_reg; un_a = un_reg; vn_a = vn_reg; tn_a = tn_reg;
        end
        uv_a = un_a + vn_a;
        hit_next = (det_a > $signed(SW'(margin)))
                   && (un_a >= 0) && (un_a <= det_a)
                   && (vn_a >= 0) && (uv_a <= det_a)
                   && (tn_a > 0) && (tn_a <= det_a);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pdh_reg[k] <= mul_hi(e1_i[k], h_i[k]);
                pdl_reg[k] <= mul_lo(e1_i[k], h_i[k]);
                puh_reg[k] <= mul_hi(s_i[k], h_i[k]);
                pul_reg[k] <= mul_lo(s_i[k], h_i[k]);
                pvh_reg[k] <= mul_hi(d_i[k], q_i[k]);
                pvl_reg[k] <= mul_lo(d_i[k], q_i[k]);
                pth_reg[k] <= mul_hi(e2_i[k], q_i[k]);
                ptl_reg[k] <= mul_lo(e2_i[k], q_i[k]);
            end
            det_reg <= term(pdh_reg[0], pdl_reg[0]) + term(pdh_reg[1], pdl_reg[1])
                       + term(pdh_reg[2], pdl_reg[2]);
            un_reg  <= term(puh_reg[0], pul_reg[0]) + term(puh_reg[1], pul_reg[1])
                       + term(puh_reg[2], pul_reg[2]);
            vn_reg  <= term(pvh_reg[0], pvl_reg[0]) + term(pvh_reg[1], pvl_reg[1])
                       + term(pvh_reg[2], pvl_reg[2]);
            tn_reg  <= term(pth_reg[0], ptl_reg[0]) + term(pth_reg[1], ptl_reg[1])
                       + term(pth_reg[2], ptl_reg[2]);
            hit_reg <= hit_next;
        end
    end

    assign hit_o = hit_reg;
endmodule
`default_nettype wire

// ----- rtl/segment_triangle_intersect.sv -----
`default_nettype none
// Throughput: one test per cycle unless an untaken result at the output stalls
// the pipeline; five register stages (differences, cross products, dot products,
// sums, compare) advance together on a shared enable.
// Reset (synchronous, aresetn low): pipeline valid bits clear, margin returns to 1.
module segment_triangle_intersect #(
    parameter int COORD_BITS = sti_pkg::COORD_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // seg_start[59:0], seg_end, vertex_a, vertex_b, vertex_c[299:240]
    input  wire logic [sti_pkg::IN_BITS-1:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit[0], zero fill above
    output logic [7:0]        m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [sti_pkg::MARGIN_BITS-1:0] cfg_data
);
    localparam int DEPTH = 5;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW + 1;

    logic [sti_pkg::MARGIN_BITS-1:0] margin_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             en;
    logic             hit;
    logic signed [DW-1:0] e1 [3], e2 [3], d [3], s [3];
    logic signed [PW-1:0] h [3], q [3];

    // pipeline advances unless the output holds an untaken result
    assign en        = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[DEPTH-1];
    assign m_tdata   = {7'd0, hit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            margin_reg <= sti_pkg::MARGIN_RESET;
        end else begin
            if (en) vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
            if (cfg_valid) margin_reg <= cfg_data;
        end
    end

    sti_vec #(.COORD_BITS(COORD_BITS)) u_vec (
        .aclk(aclk), .en(en), .pts(s_tdata),
        .e1_o(e1), .e2_o(e2), .d_o(d), .s_o(s), .h_o(h), .q_o(q)
    );

    sti_dot #(.COORD_BITS(COORD_BITS)) u_dot (
        .aclk(aclk), .en(en), .margin(margin_reg),
        .e1_i(e1), .e2_i(e2), .d_i(d), .s_i(s), .h_i(h), .q_i(q),
        .hit_o(hit)
    );
endmodule
`default_nettype wire

// ----- rtl/sti_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
// Port-level checks for the intersection pipeline
module sti_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    `ASSERT_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[7:1] == 7'd0, "pad bits set")
    `ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_tvalid, s_tready, "input stalled while output empty")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
endmodule

bind segment_triangle_intersect sti_checker u_sti_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ----- dv/segment_triangle_intersect_test.sv -----
`timescale 1ns / 100ps
`default_nettype none

module segment_triangle_intersect_test;

    localparam int CB = sti_pkg::COORD_BITS_DEF;
    localparam int LATENCY = 5;
    localparam int IDLE_LIMIT = 5000;
    localparam int N_RANDOM = 1500;
    localparam int HOLD_CYCLES = 300;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [63:0] lng_t;
    typedef logic signed [127:0] wide_t;
    typedef logic [sti_pkg::POINT_BITS-1:0] point_t;
    typedef logic [sti_pkg::MARGIN_BITS-1:0] margin_t;

    // Kinds of expected value in the directed table
    typedef enum logic [1:0] {EXP_MODEL, EXP_MISS, EXP_HIT} exp_kind_t;

    typedef struct packed {
        point_t p_start, p_end, va, vb, vc;
    } tri_test_t;

    typedef struct {
        tri_test_t t;
        exp_kind_t kind;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [sti_pkg::IN_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    margin_t cfg_data = '0;

    margin_t margin_mirror;
    logic expected_hits[$];
    int err_count = 0;
    int idle_cycles = 0;
    bit hold_sink = 1'b0;

    always #5 aclk = ~aclk;

    segment_triangle_intersect i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    function automatic lng_t coord(point_t p, int k);
        coord_t c;
        c = p[k*CB +: CB];
        return lng_t'(c);
    endfunction

    // Division-free Moller-Trumbore; all terms exact at 128 bits
    function automatic logic predict_hit(tri_test_t t, margin_t margin);
        lng_t e1[3], e2[3], d[3], s[3], h[3], q[3];
        wide_t det, un, vn, tn;
        for (int k = 0; k < 3; k++) begin
            e1[k] = coord(t.vb, k) - coord(t.va, k);
            e2[k] = coord(t.vc, k) - coord(t.va, k);
            d[k] = coord(t.p_end, k) - coord(t.p_start, k);
            s[k] = coord(t.p_start, k) - coord(t.va, k);
        end
        for (int k = 0; k < 3; k++) begin
            h[k] = d[(k+1)%3] * e2[(k+2)%3] - d[(k+2)%3] * e2[(k+1)%3];
            q[k] = s[(k+1)%3] * e1[(k+2)%3] - s[(k+2)%3] * e1[(k+1)%3];
        end
        det = 0; un = 0; vn = 0; tn = 0;
        for (int k = 0; k < 3; k++) begin
            det += wide_t'(e1[k]) * wide_t'(h[k]);
            un += wide_t'(s[k]) * wide_t'(h[k]);
            vn += wide_t'(d[k]) * wide_t'(q[k]);
            tn += wide_t'(e2[k]) * wide_t'(q[k]);
        end
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        return det > wide_t'({1'b0, margin}) && un >= 0 && un <= det && vn >= 0
            && un + vn <= det && tn > 0 && tn <= det;
    endfunction

    function automatic point_t pt(lng_t x, lng_t y, lng_t z);
        return {coord_t'(z), coord_t'(y), coord_t'(x)};
    endfunction

    function automatic point_t rand_point(int span);
        return pt(lng_t'($urandom_range(2*span)) - span,
            lng_t'($urandom_range(2*span)) - span,
            lng_t'($urandom_range(2*span)) - span);
    endfunction

    function automatic point_t raw_point();
        return point_t'({$urandom, $urandom});
    endfunction

    // Segment aimed at a random point near the triangle, straddling its plane; one in ten collapses to a point
    function automatic tri_test_t aimed_test(int span);
        tri_test_t t;
        lng_t u, v, tt, px[3], dv[3];
        t.va = rand_point(span);
        t.vb = rand_point(span);
        t.vc = rand_point(span);
        u = lng_t'($urandom_range(1200)) - 100;
        v = lng_t'($urandom_range(1200)) - 100;
        tt = lng_t'($urandom_range(1000)) + 1;
        for (int k = 0; k < 3; k++) begin
            px[k] = coord(t.va, k) + ((coord(t.vb, k) - coord(t.va, k)) * u
                + (coord(t.vc, k) - coord(t.va, k)) * v) / 1000;
            dv[k] = lng_t'($urandom_range(2*span)) - span;
        end
        t.p_start = pt(px[0] - dv[0] * tt / 1000, px[1] - dv[1] * tt / 1000,
            px[2] - dv[2] * tt / 1000);
        t.p_end = pt(px[0] + dv[0] * (1000 - tt) / 1000,
            px[1] + dv[1] * (1000 - tt) / 1000, px[2] + dv[2] * (1000 - tt) / 1000);
        if ($urandom_range(9) == 0) t.p_end = t.p_start;
        return t;
    endfunction

    // Drive one test and wait for its transfer; valid drops only while idling
    task automatic send_test(tri_test_t t, exp_kind_t kind);
        logic hit;
        int gap;
        gap = $urandom_range(7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        hit = predict_hit(t, margin_mirror);
        if (kind != EXP_MODEL && hit != (kind == EXP_HIT)) begin
            $error("table hit: expected %0d, model %0d", kind == EXP_HIT, hit);
            err_count++;
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t.vc, t.vb, t.va, t.p_end, t.p_start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_hits.push_back(hit);
        @(negedge aclk);
    endtask

    task automatic drain_then_write(margin_t value);
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(negedge aclk);
        repeat (LATENCY + 2) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        margin_mirror = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall per result, plus one long hold-off
    initial begin
        int wait_n;
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_tready <= 1'b0;
            end else begin
                wait_n = $urandom_range(3) == 0 ? 0 : $urandom_range(7);
                if (wait_n != 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_n) @(negedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
                while (!(m_tvalid && m_tready)) @(posedge aclk);
            end
        end
    end

    initial begin
        wait (aresetn);
        repeat (200) @(posedge aclk);
        hold_sink = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_sink = 1'b0;
    end

    // Compare results, count idle cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result: hit %0d", m_tdata[0]);
                    err_count++;
                end else begin
                    logic exp_hit;
                    exp_hit = expected_hits.pop_front();
                    if (m_tdata[0] !== exp_hit) begin
                        $error("hit: expected %0d, actual %0d", exp_hit, m_tdata[0]);
                        err_count++;
                    end
                    if (m_tdata[7:1] !== 7'd0) begin
                        $error("fill: expected 0, actual %0h", m_tdata[7:1]);
                        err_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                    || hold_sink)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("segment_triangle_intersect_test: errors");
                $finish;
            end
        end
    end

    initial begin
        dir_row_t rows[$];
        point_t A, B, C;
        margin_t margins[4];
        A = pt(0, 0, 0);
        B = pt(4096, 0, 0);
        C = pt(0, 4096, 0);
        // Right triangle in z = 0; segments along z
        rows.push_back('{'{pt(1000, 1000, -4096), pt(1000, 1000, 4096), A, B, C}, EXP_HIT});
        rows.push_back('{'{pt(1000, 1000, 4096), pt(1000, 1000, -4096), A, B, C}, EXP_HIT});
        rows.push_back('{'{pt(3000, 3000, -4096), pt(3000, 3000, 4096), A, B, C}, EXP_MISS});
        // On an edge, at a vertex, on the hypotenuse, just outside an edge
        rows.push_back('{'{pt(0, 1000, -4096), pt(0, 1000, 4096), A, B, C}, EXP_HIT});
        rows.push_back('{'{pt(0, 0, -4096), pt(0, 0, 4096), A, B, C}, EXP_HIT});
        rows.push_back('{'{pt(2048, 2048, -4096), pt(2048, 2048, 4096), A, B, C}, EXP_HIT});
        rows.push_back('{'{pt(-1, 1000, -4096), pt(-1, 1000, 4096), A, B, C}, EXP_MISS});
        // Segment ending on plane hits, starting on plane misses, stopping short misses
        rows.push_back('{'{pt(1000, 1000, -4096), pt(1000, 1000, 0), A, B, C}, EXP_HIT});
        rows.push_back('{'{pt(1000, 1000, 0), pt(1000, 1000, 4096), A, B, C}, EXP_MISS});
        rows.push_back('{'{pt(1000, 1000, -4096), pt(1000, 1000, -1), A, B, C}, EXP_MISS});
        // Degenerate: point segment, collapsed triangle, parallel segment
        rows.push_back('{'{pt(1000, 1000, 5), pt(1000, 1000, 5), A, B, C}, EXP_MISS});
        rows.push_back('{'{pt(1000, 1000, -9), pt(1000, 1000, 9), A, A, C}, EXP_MISS});
        rows.push_back('{'{pt(-9, 9, 0), pt(900, 900, 0), A, B, C}, EXP_MISS});
        // Tiny triangle: det = 1 at or below the reset margin
        rows.push_back('{'{pt(0, 0, -1), pt(0, 0, 0), A, pt(1, 0, 0), pt(0, 1, 0)}, EXP_MISS});
        // Coordinate extremes and high bits of the word
        rows.push_back('{'{pt(-524288, -524288, -524288), pt(524287, 524287, 524287),
            pt(-524288, 524287, 0), pt(524287, -524288, 0), pt(0, 0, 524287)}, EXP_MODEL});
        rows.push_back('{'{{60{1'b1}}, '0, {60{1'b1}}, pt(524287, 0, 0), pt(0, 524287, 0)},
            EXP_MODEL});
        rows.push_back('{'{{60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}, {60{1'b1}}},
            EXP_MISS});
        rows.push_back('{'{{3{20'h80000}}, {3{20'h7FFFF}}, {3{20'h55555}}, {3{20'hAAAAA}},
            {3{20'h0F0F0}}}, EXP_MODEL});

        margin_mirror = sti_pkg::MARGIN_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_test(rows[i].t, rows[i].kind);

        // Margin phases, extremes included
        margins[0] = 20'd0;
        margins[1] = 20'hFFFFF;
        margins[2] = margin_t'($urandom);
        margins[3] = 20'd1;
        for (int ph = 0; ph < 4; ph++) begin
            drain_then_write(ph == 2 ? margins[2] & 20'h003FF : margins[ph]);
            send_test('{pt(0, 0, -1), pt(0, 0, 0), A, pt(1, 0, 0), pt(0, 1, 0)}, EXP_MODEL);
            send_test('{pt(10, 10, -4096), pt(10, 10, 4096), A, pt(64, 0, 0),
                pt(0, 64, 0)}, EXP_MODEL);
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                int sel;
                sel = $urandom_range(9);
                if (sel < 6)
                    send_test(aimed_test(sel < 3 ? 64 : 100000), EXP_MODEL);
                else if (sel < 9)
                    send_test('{rand_point(524287), rand_point(524287),
                        rand_point(524287), rand_point(524287), rand_point(524287)},
                        EXP_MODEL);
                else
                    send_test('{raw_point(), raw_point(), raw_point(), raw_point(),
                        raw_point()}, EXP_MODEL);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_hits.size() != 0) @(negedge aclk);
        repeat (LATENCY * 4) @(negedge aclk);
        if (err_count == 0)
            $display("segment_triangle_intersect_test: clean");
        else
            $display("segment_triangle_intersect_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
